// ===== design/ctb_pkg.sv =====
// Shared types and constants of the circular trace buffer.
package ctb_pkg;

    localparam int WORD_W     = 64;
    localparam int SKIP_W     = 10;
    localparam int SLOT_IDX_W = 10;
    localparam int COUNT_W    = 11;
    localparam int CFG_W      = 11;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 88;

    typedef enum logic [1:0] {
        MODE_ENTER,
        MODE_FIRST,
        MODE_NEXT,
        MODE_SKIP
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_EMIT,
        ST_MISS
    } state_t;

    typedef struct packed {
        logic do_enter;
        logic do_first;
        logic do_next;
        logic skip_start;
        logic div_step;
        logic skip_finish;
        logic rd_issue;
        logic word_inc;
        logic out_found;
    } cmd_t;

    typedef struct packed {
        logic miss;
        logic div_done;
        logic last_word;
    } sts_t;

endpackage

// ===== design/ctb_mod.sv =====
// Shift-subtract remainder unit, one dividend bit per cycle while step is high.
module ctb_mod #(
    parameter int NW = 11,
    parameter int DW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          step,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [DW-1:0] rem,
    output logic          done
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   dvd_reg, dvd_next;
    logic [DW-1:0]   div_reg, div_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW:0]     trial;

    always_comb begin
        trial    = {rem_reg, dvd_reg[NW-1]};
        dvd_next = dvd_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
            cnt_next = CNTW'(NW);
        end else if (step && cnt_reg != '0) begin
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DW'(trial - {1'b0, div_reg});
            end else begin
                rem_next = DW'(trial);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = (cnt_reg == '0);

endmodule

// ===== design/ctb_dp.sv =====
// Datapath: ring pointers, trace memory, remainder unit and result fields.
module ctb_dp #(
    parameter int MAX_ENTRIES     = 1024,
    parameter int WORDS_PER_ENTRY = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ctb_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [ctb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic [1:0]                      s_tuser,
    input  ctb_pkg::cmd_t                   cmd,
    output ctb_pkg::sts_t                   sts,
    output logic [ctb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    import ctb_pkg::*;

    localparam int SW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int XW    = (CW > CFG_W) ? CW : CFG_W;
    localparam int OW    = (WORDS_PER_ENTRY > 1) ? $clog2(WORDS_PER_ENTRY) : 1;
    localparam int DEPTH = MAX_ENTRIES * WORDS_PER_ENTRY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(MAX_ENTRIES + 1023);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [CW-1:0] ring_size_reg, ring_size_next;
    logic [SW-1:0] write_slot_reg, write_slot_next;
    logic [OW-1:0] word_offset_reg, word_offset_next;
    logic          wrapped_reg, wrapped_next;
    logic [SW-1:0] read_start_reg, read_start_next;
    logic [SW-1:0] read_slot_reg, read_slot_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [OW-1:0] word_reg, word_next;

    logic [WORD_W-1:0] word_data;
    logic [SKIP_W-1:0] skip_amount;
    mode_t             mode;
    logic [CW-1:0]     count;
    logic [CW-1:0]     first_idx;
    logic [XW-1:0]     cfg_x;
    logic [CW-1:0]     cfg_clamped;
    logic [AW-1:0]     waddr, raddr;
    logic              wr_en, rd_en;
    logic [CW-1:0]     rem;
    logic              div_done;

    assign word_data   = s_tdata[WORD_W-1:0];
    assign skip_amount = s_tdata[WORD_W+SKIP_W-1:WORD_W];
    assign mode        = mode_t'(s_tuser);

    assign count     = wrapped_reg ? ring_size_reg : CW'(write_slot_reg);
    assign first_idx = wrapped_reg ? CW'(write_slot_reg) : '0;

    always_comb begin
        cfg_x = XW'(cfg_wdata);
        if (cfg_wdata == '0) begin
            cfg_clamped = CW'(1);
        end else if (cfg_x > XW'(MAX_ENTRIES)) begin
            cfg_clamped = CW'(MAX_ENTRIES);
        end else begin
            cfg_clamped = CW'(cfg_wdata);
        end
    end

    always_comb begin
        case (mode)
            MODE_FIRST: sts.miss = (first_idx + 1'b1) > count;
            MODE_NEXT:  sts.miss = (read_slot_reg == read_start_reg);
            MODE_SKIP:  sts.miss = (count == '0) || (read_slot_reg == read_start_reg);
            default:    sts.miss = 1'b0;
        endcase
        sts.div_done  = div_done;
        sts.last_word = (word_reg == OW'(WORDS_PER_ENTRY - 1));
    end

    ctb_mod #(
        .NW (NW),
        .DW (CW)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.skip_start),
        .step     (cmd.div_step),
        .dividend (NW'(read_slot_reg) + NW'(skip_amount)),
        .divisor  (count),
        .rem      (rem),
        .done     (div_done)
    );

    always_comb begin
        ring_size_next   = ring_size_reg;
        write_slot_next  = write_slot_reg;
        word_offset_next = word_offset_reg;
        wrapped_next     = wrapped_reg;
        read_start_next  = read_start_reg;
        read_slot_next   = read_slot_reg;
        slot_next        = slot_reg;
        word_next        = word_reg;
        if (cfg_we) begin
            ring_size_next = cfg_clamped;
        end
        if (cmd.do_enter) begin
            if (s_tlast) begin
                word_offset_next = '0;
                if ((CW'(write_slot_reg) + 1'b1) >= ring_size_reg) begin
                    write_slot_next = '0;
                    wrapped_next    = 1'b1;
                end else begin
                    write_slot_next = write_slot_reg + 1'b1;
                end
            end else if (int'(word_offset_reg) + 1 < WORDS_PER_ENTRY) begin
                word_offset_next = word_offset_reg + 1'b1;
            end
        end
        if (cmd.do_first) begin
            read_start_next = SW'(first_idx);
            slot_next       = SW'(first_idx);
            if ((first_idx + 1'b1) < count) begin
                read_slot_next = SW'(first_idx + 1'b1);
            end else begin
                read_slot_next = '0;
            end
        end
        if (cmd.do_next) begin
            slot_next = read_slot_reg;
            if ((CW'(read_slot_reg) + 1'b1) >= count) begin
                read_slot_next = '0;
            end else begin
                read_slot_next = read_slot_reg + 1'b1;
            end
        end
        if (cmd.skip_finish) begin
            slot_next = SW'(rem);
            if ((rem + 1'b1) == count) begin
                read_slot_next = '0;
            end else begin
                read_slot_next = SW'(rem + 1'b1);
            end
        end
        if (cmd.rd_issue) begin
            word_next = '0;
        end else if (cmd.word_inc) begin
            word_next = word_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg   <= CW'(MAX_ENTRIES);
            write_slot_reg  <= '0;
            word_offset_reg <= '0;
            wrapped_reg     <= 1'b0;
            read_start_reg  <= '0;
            read_slot_reg   <= '0;
        end else begin
            ring_size_reg   <= ring_size_next;
            write_slot_reg  <= write_slot_next;
            word_offset_reg <= word_offset_next;
            wrapped_reg     <= wrapped_next;
            read_start_reg  <= read_start_next;
            read_slot_reg   <= read_slot_next;
        end
        slot_reg <= slot_next;
        word_reg <= word_next;
    end

    assign wr_en = cmd.do_enter;
    assign rd_en = cmd.rd_issue || cmd.word_inc;
    assign waddr = AW'(AW'(write_slot_reg) * AW'(WORDS_PER_ENTRY)) + AW'(word_offset_reg);
    assign raddr = AW'(AW'(slot_reg) * AW'(WORDS_PER_ENTRY))
                 + (cmd.rd_issue ? AW'(0) : AW'(word_reg + 1'b1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= word_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb begin
        m_tdata = '0;
        if (cmd.out_found) begin
            m_tdata[WORD_W-1:0]                  = rdata_reg;
            m_tdata[WORD_W+SLOT_IDX_W-1:WORD_W]  = SLOT_IDX_W'(slot_reg);
        end
        m_tdata[WORD_W+SLOT_IDX_W+COUNT_W-1:WORD_W+SLOT_IDX_W] = COUNT_W'(count);
        m_tuser = cmd.out_found;
        m_tlast = !cmd.out_found || sts.last_word;
    end

endmodule

// ===== design/ctb_ctrl.sv =====
// Controller: request decode and read-out sequencing.
module ctb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic [1:0]    s_tuser,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  ctb_pkg::sts_t sts,
    output ctb_pkg::cmd_t cmd
);

    import ctb_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode;
    logic   accept;

    assign mode   = mode_t'(s_tuser);
    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_ENTER: state_next = ST_IDLE;
                        MODE_FIRST: state_next = sts.miss ? ST_MISS : ST_FETCH;
                        MODE_NEXT:  state_next = sts.miss ? ST_MISS : ST_FETCH;
                        MODE_SKIP:  state_next = sts.miss ? ST_MISS : ST_DIV;
                    endcase
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_tready && sts.last_word) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    unique case (mode)
                        MODE_ENTER: cmd.do_enter   = 1'b1;
                        MODE_FIRST: cmd.do_first   = 1'b1;
                        MODE_NEXT:  cmd.do_next    = 1'b1;
                        MODE_SKIP:  cmd.skip_start = !sts.miss;
                    endcase
                end
            end
            ST_DIV: begin
                cmd.div_step    = !sts.div_done;
                cmd.skip_finish = sts.div_done;
            end
            ST_FETCH: cmd.rd_issue = 1'b1;
            ST_EMIT: begin
                m_tvalid      = 1'b1;
                cmd.out_found = 1'b1;
                cmd.word_inc  = m_tready && !sts.last_word;
            end
            ST_MISS: m_tvalid = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/circular_trace_buffer.sv =====
// Top level of the circular trace buffer: ring of trace records with read-out walks.
//
// Capture requests (tuser 0) are taken one per cycle while the block is idle; each
// word is written to the trace memory in the cycle it is accepted. A read request
// (first, next, skip) is taken only when the block is idle and then owns the block
// until its results are delivered. A found record passes through a memory fetch
// state and then WORDS_PER_ENTRY output words, one word per cycle when the sink is
// ready. A not-found result is a single output transfer. A skip request first runs
// the shift-subtract remainder unit. The trace memory is not cleared after reset;
// reading a slot word never written returns garbage.
module circular_trace_buffer #(
    parameter int MAX_ENTRIES     = 1024,
    parameter int WORDS_PER_ENTRY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ctb_pkg::CFG_W-1:0]     cfg_wdata,   // ring_entries
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ctb_pkg::S_TDATA_W-1:0] s_tdata,     // word_data[63:0], skip_amount[73:64]
    input  logic                          s_tlast,     // word_last
    input  logic [1:0]                    s_tuser,     // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ctb_pkg::M_TDATA_W-1:0] m_tdata,     // read_word[63:0], slot_index[73:64],
                                                       // stored_count[84:74]
    output logic                          m_tlast,     // word_end
    output logic                          m_tuser      // found
);

    import ctb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ctb_dp #(
        .MAX_ENTRIES     (MAX_ENTRIES),
        .WORDS_PER_ENTRY (WORDS_PER_ENTRY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
